// ===== hdl/plm_pkg.sv =====
// Shared types, constants and helper functions of the light level mapper.
`default_nettype none

package plm_pkg;

   // Fixed field widths of the request and result items.
   localparam int unsigned KIND_BITS      = 3;
   localparam int unsigned COLOR_BITS     = 32;
   localparam int unsigned MS_BITS        = 16;
   localparam int unsigned LED_BITS       = 8;
   localparam int unsigned CSR_INDEX_BITS = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_BACKLIGHT_MAX = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WHITE_MAX     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLUE_MAX      = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GREEN_MAX     = 2'd3;

   // Luma weights, summing to 256.
   localparam logic [15:0] WEIGHT_RED   = 16'd77;
   localparam logic [15:0] WEIGHT_GREEN = 16'd150;
   localparam logic [15:0] WEIGHT_BLUE  = 16'd29;

   // Division by 127 through a reciprocal: exact for dividends below 2^24.
   localparam int unsigned QUOT_BITS   = 24;
   localparam int unsigned RECIP_BITS  = 25;
   localparam int unsigned RECIP_SHIFT = 31;
   localparam logic [RECIP_BITS-1:0] RECIP_127 = 25'd16909321;

   typedef enum logic [1:0] {
      JOB_UNSUPPORTED,
      JOB_BACKLIGHT,
      JOB_LEDS
   } job_kind_type;

   // One classified item, as handed from the front end to the back end.
   typedef struct packed {
      job_kind_type          kind;
      logic [COLOR_BITS-1:0] color;
      logic                  timed;
      logic [MS_BITS-1:0]    on_ms;
      logic [MS_BITS-1:0]    off_ms;
   } job_type;

   typedef struct packed {
      logic [LED_BITS-1:0] white;
      logic [LED_BITS-1:0] blue;
      logic [LED_BITS-1:0] green;
   } led_max_type;

   // Exact floor(x / 255) for any x up to 255 * 255, such as a product of two 8-bit values.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/plm_if.sv =====
// Handshake interfaces of the request, result and configuration channels.
`default_nettype none

interface plm_req_if import plm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  light_kind;
   logic [COLOR_BITS-1:0] argb_color;
   logic                  timed_flash;
   logic [MS_BITS-1:0]    on_time_ms;
   logic [MS_BITS-1:0]    off_time_ms;

   modport source (output valid, light_kind, argb_color, timed_flash, on_time_ms,
                   off_time_ms, input ready);
   modport sink   (input valid, light_kind, argb_color, timed_flash, on_time_ms,
                   off_time_ms, output ready);
endinterface

interface plm_rsp_if import plm_pkg::*; #(parameter int BACKLIGHT_BITS = 12) ();
   logic                      valid;
   logic                      ready;
   logic                      status_code;
   logic                      target_group;
   logic [BACKLIGHT_BITS-1:0] backlight_level;
   logic [LED_BITS-1:0]       white_level;
   logic [LED_BITS-1:0]       blue_level;
   logic [LED_BITS-1:0]       green_level;
   logic                      breathing_on;
   logic [MS_BITS-1:0]        blink_on_ms;
   logic [MS_BITS-1:0]        blink_off_ms;

   modport source (output valid, status_code, target_group, backlight_level, white_level,
                   blue_level, green_level, breathing_on, blink_on_ms, blink_off_ms,
                   input ready);
   modport sink   (input valid, status_code, target_group, backlight_level, white_level,
                   blue_level, green_level, breathing_on, blink_on_ms, blink_off_ms,
                   output ready);
endinterface

interface plm_csr_if import plm_pkg::*; #(parameter int DATA_BITS = 12) ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [DATA_BITS-1:0]      wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/plm_front.sv =====
// Front end: accepts requests, updates the slot cache and picks the winning slot.
`default_nettype none

module plm_front import plm_pkg::*; #(
   parameter int SLOT_COUNT = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   plm_req_if.sink   req,
   output job_type   push_job,
   output logic      push_valid,
   input  wire logic push_ready
);

   localparam logic [KIND_BITS-1:0] LAST_SLOT = KIND_BITS'(SLOT_COUNT - 1);

   logic [COLOR_BITS-1:0] color_ff  [SLOT_COUNT];
   logic                  timed_ff  [SLOT_COUNT];
   logic [MS_BITS-1:0]    on_ms_ff  [SLOT_COUNT];
   logic [MS_BITS-1:0]    off_ms_ff [SLOT_COUNT];

   logic supported;
   logic accept;

   assign supported  = (req.light_kind <= LAST_SLOT);
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   // Classification and priority pick; the incoming item already counts as cached.
   always_comb begin
      job_type eff;
      push_job.kind   = JOB_LEDS;
      push_job.color  = req.argb_color;
      push_job.timed  = req.timed_flash;
      push_job.on_ms  = req.on_time_ms;
      push_job.off_ms = req.off_time_ms;
      eff             = push_job;
      if (!supported) begin
         push_job.kind = JOB_UNSUPPORTED;
      end else if (req.light_kind == LAST_SLOT) begin
         push_job.kind = JOB_BACKLIGHT;
      end else begin
         // Walk from the lowest rank upwards so that the highest rank lit wins.
         for (int s = SLOT_COUNT - 2; s >= 0; s--) begin
            if (req.light_kind == KIND_BITS'(s)) begin
               eff.color  = req.argb_color;
               eff.timed  = req.timed_flash;
               eff.on_ms  = req.on_time_ms;
               eff.off_ms = req.off_time_ms;
            end else begin
               eff.color  = color_ff[s];
               eff.timed  = timed_ff[s];
               eff.on_ms  = on_ms_ff[s];
               eff.off_ms = off_ms_ff[s];
            end
            if (eff.color[23:0] != 24'd0) begin
               push_job.color  = eff.color;
               push_job.timed  = eff.timed;
               push_job.on_ms  = eff.on_ms;
               push_job.off_ms = eff.off_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            color_ff[s]  <= '0;
            timed_ff[s]  <= 1'b0;
            on_ms_ff[s]  <= '0;
            off_ms_ff[s] <= '0;
         end
      end else if (accept && supported) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            if (req.light_kind == KIND_BITS'(s)) begin
               color_ff[s]  <= req.argb_color;
               timed_ff[s]  <= req.timed_flash;
               on_ms_ff[s]  <= req.on_time_ms;
               off_ms_ff[s] <= req.off_time_ms;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/plm_queue.sv =====
// Two-entry queue of classified items between the front and back ends.
`default_nettype none

module plm_queue import plm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type push_job,
   input  wire logic    push_valid,
   output logic         push_ready,
   output job_type      pop_job,
   output logic         pop_valid,
   input  wire logic    pop_ready
);

   localparam int DEPTH = 2;

   job_type    mem_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/plm_back.sv =====
// Back end: luma, level scaling and the registered result stage.
`default_nettype none

module plm_back import plm_pkg::*; #(
   parameter int BACKLIGHT_BITS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire job_type                   pop_job,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire logic [BACKLIGHT_BITS-1:0] backlight_max,
   input  wire led_max_type               led_max,
   plm_rsp_if.source                      rsp
);

   localparam int PROD_BITS = LED_BITS + BACKLIGHT_BITS;
   localparam int WIDE_BITS = QUOT_BITS + RECIP_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALPHA,
      ST_LUMA,
      ST_MULT,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   job_type                   job_ff;
   logic [1:0]                ch_ff;
   logic [15:0]               prod_r_ff;
   logic [15:0]               prod_g_ff;
   logic [15:0]               prod_b_ff;
   logic [LED_BITS-1:0]       luma_ff;
   logic [PROD_BITS-1:0]      prod_ff;

   // Working result, copied to the output register when the item is complete.
   logic                      wk_status_ff;
   logic                      wk_group_ff;
   logic [BACKLIGHT_BITS-1:0] wk_backlight_ff;
   logic [LED_BITS-1:0]       wk_white_ff;
   logic [LED_BITS-1:0]       wk_blue_ff;
   logic [LED_BITS-1:0]       wk_green_ff;
   logic                      wk_breath_ff;
   logic [MS_BITS-1:0]        wk_on_ff;
   logic [MS_BITS-1:0]        wk_off_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_status_ff;
   logic                      rsp_group_ff;
   logic [BACKLIGHT_BITS-1:0] rsp_backlight_ff;
   logic [LED_BITS-1:0]       rsp_white_ff;
   logic [LED_BITS-1:0]       rsp_blue_ff;
   logic [LED_BITS-1:0]       rsp_green_ff;
   logic                      rsp_breath_ff;
   logic [MS_BITS-1:0]        rsp_on_ff;
   logic [MS_BITS-1:0]        rsp_off_ff;

   logic [BACKLIGHT_BITS-1:0] top_level;
   logic [BACKLIGHT_BITS-1:0] top_minus;
   logic [15:0]               luma_sum;
   logic [WIDE_BITS-1:0]      recip_prod;
   logic [BACKLIGHT_BITS-1:0] level;
   logic                      last_ch;
   logic                      pop_breath;

   assign pop_ready  = (state_ff == ST_IDLE);
   assign pop_breath = (pop_job.kind == JOB_LEDS) && pop_job.timed;

   // Maximum level of the output being scaled; zero behaves as one.
   always_comb begin
      if (job_ff.kind == JOB_BACKLIGHT) begin
         top_level = backlight_max;
      end else begin
         unique case (ch_ff)
            2'd0:    top_level = BACKLIGHT_BITS'(led_max.white);
            2'd1:    top_level = BACKLIGHT_BITS'(led_max.blue);
            default: top_level = BACKLIGHT_BITS'(led_max.green);
         endcase
      end
      top_minus = (top_level == '0) ? '0 : top_level - BACKLIGHT_BITS'(1);
   end

   assign luma_sum = WEIGHT_RED * 16'(div255(prod_r_ff))
                   + WEIGHT_GREEN * 16'(div255(prod_g_ff))
                   + WEIGHT_BLUE * 16'(div255(prod_b_ff));

   // floor(p / 254) = floor((p >> 1) / 127), the latter by reciprocal.
   assign recip_prod = WIDE_BITS'(QUOT_BITS'(prod_ff >> 1)) * WIDE_BITS'(RECIP_127);
   assign level      = recip_prod[RECIP_SHIFT +: BACKLIGHT_BITS] + BACKLIGHT_BITS'(1);
   assign last_ch    = (job_ff.kind == JOB_BACKLIGHT) || (ch_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The finish step reloads the output register itself.
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  job_ff          <= pop_job;
                  ch_ff           <= 2'd0;
                  wk_status_ff    <= (pop_job.kind == JOB_UNSUPPORTED);
                  wk_group_ff     <= (pop_job.kind == JOB_LEDS);
                  wk_backlight_ff <= '0;
                  wk_white_ff     <= '0;
                  wk_blue_ff      <= '0;
                  wk_green_ff     <= '0;
                  wk_breath_ff    <= pop_breath;
                  wk_on_ff        <= pop_breath ? pop_job.on_ms : '0;
                  wk_off_ff       <= pop_breath ? pop_job.off_ms : '0;
                  // Unsupported and timed items need no arithmetic.
                  state_ff        <= ((pop_job.kind == JOB_UNSUPPORTED) || pop_breath) ?
                                     ST_FINISH : ST_ALPHA;
               end
            end
            ST_ALPHA: begin
               // An opaque alpha scales by 255/255, which leaves each channel unchanged.
               prod_r_ff <= 16'(job_ff.color[23:16]) * 16'(job_ff.color[31:24]);
               prod_g_ff <= 16'(job_ff.color[15:8])  * 16'(job_ff.color[31:24]);
               prod_b_ff <= 16'(job_ff.color[7:0])   * 16'(job_ff.color[31:24]);
               state_ff  <= ST_LUMA;
            end
            ST_LUMA: begin
               luma_ff  <= luma_sum[15:8];
               state_ff <= (luma_sum[15:8] == '0) ? ST_FINISH : ST_MULT;
            end
            ST_MULT: begin
               prod_ff  <= PROD_BITS'(luma_ff - LED_BITS'(1)) * PROD_BITS'(top_minus);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (job_ff.kind == JOB_BACKLIGHT) begin
                  wk_backlight_ff <= level;
               end else begin
                  unique case (ch_ff)
                     2'd0:    wk_white_ff <= level[LED_BITS-1:0];
                     2'd1:    wk_blue_ff  <= level[LED_BITS-1:0];
                     default: wk_green_ff <= level[LED_BITS-1:0];
                  endcase
               end
               ch_ff    <= ch_ff + 2'd1;
               state_ff <= last_ch ? ST_FINISH : ST_MULT;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= wk_status_ff;
                  rsp_group_ff     <= wk_group_ff;
                  rsp_backlight_ff <= wk_backlight_ff;
                  rsp_white_ff     <= wk_white_ff;
                  rsp_blue_ff      <= wk_blue_ff;
                  rsp_green_ff     <= wk_green_ff;
                  rsp_breath_ff    <= wk_breath_ff;
                  rsp_on_ff        <= wk_on_ff;
                  rsp_off_ff       <= wk_off_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status_code     = rsp_status_ff;
   assign rsp.target_group    = rsp_group_ff;
   assign rsp.backlight_level = rsp_backlight_ff;
   assign rsp.white_level     = rsp_white_ff;
   assign rsp.blue_level      = rsp_blue_ff;
   assign rsp.green_level     = rsp_green_ff;
   assign rsp.breathing_on    = rsp_breath_ff;
   assign rsp.blink_on_ms     = rsp_on_ff;
   assign rsp.blink_off_ms    = rsp_off_ff;

endmodule

`default_nettype wire

// ===== hdl/prioritized_light_level_mapper.sv =====
// Top level of the light level mapper: register file and the front, queue and back ends.
// Steps: an unsupported or timed item goes from idle straight to the finish step, a
// backlight item through alpha, luma, multiply and divide, and a steady led item through
// alpha, luma and the shared multiply/divide step once per output; zero luma skips to finish.
// The back end takes a new item only when idle; the queue holds two items meanwhile.
// Reset (synchronous, active high) clears every slot to unlit and sets each maximum level.
`default_nettype none

module prioritized_light_level_mapper import plm_pkg::*; #(
   parameter int SLOT_COUNT     = 4,
   parameter int BACKLIGHT_BITS = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   plm_req_if.sink   req_port,
   plm_rsp_if.source rsp_port,
   plm_csr_if.sink   csr_port
);

   // The backlight maximum resets to 4095, cut to the width of the backlight field.
   localparam logic [31:0] BL_RESET = 32'd4095;

   logic [BACKLIGHT_BITS-1:0] backlight_max_ff;
   led_max_type               led_max_ff;

   job_type push_job;
   logic    push_valid;
   logic    push_ready;
   job_type pop_job;
   logic    pop_valid;
   logic    pop_ready;

   // The register file takes a write in every cycle. Writes must arrive only while the
   // block is idle; the block does not enforce this, and the back end reads them directly.
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_max_ff <= BL_RESET[BACKLIGHT_BITS-1:0];
         led_max_ff.white <= 8'hFF;
         led_max_ff.blue  <= 8'hFF;
         led_max_ff.green <= 8'hFF;
      end else if (csr_port.valid) begin
         unique case (csr_port.reg_index)
            REG_BACKLIGHT_MAX: backlight_max_ff <= csr_port.wr_data[BACKLIGHT_BITS-1:0];
            REG_WHITE_MAX:     led_max_ff.white <= csr_port.wr_data[LED_BITS-1:0];
            REG_BLUE_MAX:      led_max_ff.blue  <= csr_port.wr_data[LED_BITS-1:0];
            REG_GREEN_MAX:     led_max_ff.green <= csr_port.wr_data[LED_BITS-1:0];
            default:           led_max_ff       <= led_max_ff;
         endcase
      end
   end

   // The front end classifies each item, updates the cached slot and resolves the
   // notification priority in the cycle of acceptance, so that the slot cache always
   // reflects items in the order they were taken.
   plm_front #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_job   (push_job),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // The queue lets the front end keep taking items while the back end is busy.
   plm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (push_job),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_job    (pop_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // The back end computes luma and the scaled levels and holds the result item in
   // its output register until the sink takes it.
   plm_back #(
      .BACKLIGHT_BITS (BACKLIGHT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_job       (pop_job),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .backlight_max (backlight_max_ff),
      .led_max       (led_max_ff),
      .rsp           (rsp_port)
   );

endmodule

`default_nettype wire

// ===== tb/light_result_checker.sv =====
// Checker of the light level mapper: predicts each result and compares it with the block's output.
`default_nettype none

module light_result_checker import plm_pkg::*; #(
   parameter int SLOT_COUNT     = 4,
   parameter int BACKLIGHT_BITS = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   plm_req_if        req_mon,
   plm_rsp_if        rsp_mon,
   plm_csr_if        csr_mon,
   output int        error_count,
   output int        outstanding
);

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;
   localparam logic GROUP_BACKLIGHT    = 1'b0;
   localparam logic GROUP_LEDS         = 1'b1;
   localparam int   FULL_ALPHA         = 255;
   localparam int   LUMA_TOP           = 255;

   typedef struct packed {
      logic                      status;
      logic                      group;
      logic [BACKLIGHT_BITS-1:0] backlight;
      logic [LED_BITS-1:0]       white;
      logic [LED_BITS-1:0]       blue;
      logic [LED_BITS-1:0]       green;
      logic                      breathing;
      logic [MS_BITS-1:0]        on_ms;
      logic [MS_BITS-1:0]        off_ms;
   } light_result_type;

   logic [COLOR_BITS-1:0]     slot_argb  [SLOT_COUNT];
   logic                      slot_timed [SLOT_COUNT];
   logic [MS_BITS-1:0]        slot_on    [SLOT_COUNT];
   logic [MS_BITS-1:0]        slot_off   [SLOT_COUNT];
   logic [BACKLIGHT_BITS-1:0] backlight_max;
   logic [LED_BITS-1:0]       white_max;
   logic [LED_BITS-1:0]       blue_max;
   logic [LED_BITS-1:0]       green_max;

   light_result_type expected_results[$];

   function automatic int unsigned luma_of(logic [COLOR_BITS-1:0] argb);
      int unsigned alpha, red, green, blue;
      alpha = argb[31:24];
      red   = argb[23:16];
      green = argb[15:8];
      blue  = argb[7:0];
      // Translucent colours are dimmed by alpha before weighting.
      if (alpha != FULL_ALPHA) begin
         red   = red * alpha / FULL_ALPHA;
         green = green * alpha / FULL_ALPHA;
         blue  = blue * alpha / FULL_ALPHA;
      end
      return (WEIGHT_RED * red + WEIGHT_GREEN * green + WEIGHT_BLUE * blue) >> 8;
   endfunction

   function automatic int unsigned scaled_level(int unsigned luma, int unsigned top);
      if (luma == 0) return 0;
      if (top == 0) top = 1;
      return (luma - 1) * (top - 1) / (LUMA_TOP - 1) + 1;
   endfunction

   // Caches the request in its slot and works out the result it causes.
   function automatic light_result_type predict_light_result(
      logic [KIND_BITS-1:0] kind, logic [COLOR_BITS-1:0] argb, logic timed,
      logic [MS_BITS-1:0] on_ms, logic [MS_BITS-1:0] off_ms);
      light_result_type      res;
      logic [COLOR_BITS-1:0] pick_argb;
      logic                  pick_timed;
      logic [MS_BITS-1:0]    pick_on, pick_off;
      int unsigned           luma;
      bit                    found;
      res = '0;
      if (kind >= SLOT_COUNT) begin
         res.status = STATUS_UNSUPPORTED;
         return res;
      end
      slot_argb[kind]  = argb;
      slot_timed[kind] = timed;
      slot_on[kind]    = on_ms;
      slot_off[kind]   = off_ms;
      res.status = STATUS_OK;
      if (kind == SLOT_COUNT - 1) begin
         res.group     = GROUP_BACKLIGHT;
         res.backlight = BACKLIGHT_BITS'(scaled_level(luma_of(argb), backlight_max));
         return res;
      end
      pick_argb  = argb;
      pick_timed = timed;
      pick_on    = on_ms;
      pick_off   = off_ms;
      found      = 1'b0;
      for (int s = 0; s < SLOT_COUNT - 1; s++) begin
         if (!found && slot_argb[s][23:0] != '0) begin
            pick_argb  = slot_argb[s];
            pick_timed = slot_timed[s];
            pick_on    = slot_on[s];
            pick_off   = slot_off[s];
            found      = 1'b1;
         end
      end
      res.group = GROUP_LEDS;
      if (pick_timed) begin
         res.breathing = 1'b1;
         res.on_ms     = pick_on;
         res.off_ms    = pick_off;
      end else begin
         luma      = luma_of(pick_argb);
         res.white = LED_BITS'(scaled_level(luma, white_max));
         res.blue  = LED_BITS'(scaled_level(luma, blue_max));
         res.green = LED_BITS'(scaled_level(luma, green_max));
      end
      return res;
   endfunction

   function automatic int unsigned field_mismatch(string field, logic [31:0] want,
                                                  logic [31:0] got);
      if (got === want) return 0;
      $error("%s: expected %0d, got %0d", field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : monitor
      light_result_type got, want, fresh;
      int unsigned      bad;
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_argb[s]  = '0;
            slot_timed[s] = 1'b0;
            slot_on[s]    = '0;
            slot_off[s]   = '0;
         end
         backlight_max = BACKLIGHT_BITS'(4095);
         white_max     = 8'd255;
         blue_max      = 8'd255;
         green_max     = 8'd255;
         expected_results.delete();
         error_count <= 0;
         outstanding <= 0;
      end else begin
         bad = 0;
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               REG_BACKLIGHT_MAX: backlight_max = csr_mon.wr_data[BACKLIGHT_BITS-1:0];
               REG_WHITE_MAX:     white_max     = csr_mon.wr_data[LED_BITS-1:0];
               REG_BLUE_MAX:      blue_max      = csr_mon.wr_data[LED_BITS-1:0];
               REG_GREEN_MAX:     green_max     = csr_mon.wr_data[LED_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status    = rsp_mon.status_code;
            got.group     = rsp_mon.target_group;
            got.backlight = rsp_mon.backlight_level;
            got.white     = rsp_mon.white_level;
            got.blue      = rsp_mon.blue_level;
            got.green     = rsp_mon.green_level;
            got.breathing = rsp_mon.breathing_on;
            got.on_ms     = rsp_mon.blink_on_ms;
            got.off_ms    = rsp_mon.blink_off_ms;
            if (expected_results.size() == 0) begin
               $error("result item arrived with no request outstanding");
               bad++;
            end else begin
               want = expected_results.pop_front();
               bad += field_mismatch("status_code", want.status, got.status);
               bad += field_mismatch("target_group", want.group, got.group);
               bad += field_mismatch("backlight_level", want.backlight, got.backlight);
               bad += field_mismatch("white_level", want.white, got.white);
               bad += field_mismatch("blue_level", want.blue, got.blue);
               bad += field_mismatch("green_level", want.green, got.green);
               bad += field_mismatch("breathing_on", want.breathing, got.breathing);
               bad += field_mismatch("blink_on_ms", want.on_ms, got.on_ms);
               bad += field_mismatch("blink_off_ms", want.off_ms, got.off_ms);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            fresh = predict_light_result(req_mon.light_kind, req_mon.argb_color,
                                         req_mon.timed_flash, req_mon.on_time_ms,
                                         req_mon.off_time_ms);
            expected_results.insert(expected_results.size(), fresh);
         end
         error_count <= error_count + int'(bad);
         outstanding <= expected_results.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_prioritized_light_level_mapper.sv =====
// Top of the light level mapper testbench: clock, reset, stimulus, handshake pacing and verdict.
`default_nettype none

module tb_prioritized_light_level_mapper;
   import plm_pkg::*;

   localparam int SLOTS           = 4;
   localparam int BL_BITS         = 12;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int PHASE_COUNT     = 6;
   // The slowest item is a steady led request; the settle time covers it with a margin.
   localparam int SETTLE_CYCLES   = 14;

   // Slot numbers of the request channel.
   localparam logic [KIND_BITS-1:0] KIND_ATTENTION     = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_NOTIFICATIONS = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_BATTERY       = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_BACKLIGHT     = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_FIRST_UNKNOWN = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_LAST_UNKNOWN  = 3'd7;

   localparam logic STEADY = 1'b0;
   localparam logic TIMED  = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plm_req_if                            req_bus ();
   plm_rsp_if #(.BACKLIGHT_BITS(BL_BITS)) rsp_bus ();
   plm_csr_if #(.DATA_BITS(BL_BITS))      csr_bus ();

   int mismatch_count;
   int results_owed;

   // These flags let the stimulus switch idling on and off per phase, so that some
   // stretches run flat out while others have gaps on either side.
   bit sender_idles    = 1'b0;
   bit receiver_stalls = 1'b0;
   int stall_left      = 0;

   always #5 clock = ~clock;

   prioritized_light_level_mapper #(
      .SLOT_COUNT    (SLOTS),
      .BACKLIGHT_BITS(BL_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus),
      .csr_port(csr_bus)
   );

   light_result_checker #(
      .SLOT_COUNT    (SLOTS),
      .BACKLIGHT_BITS(BL_BITS)
   ) result_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .error_count(mismatch_count),
      .outstanding(results_owed)
   );

   // Most pauses come from the shortest range, some from a middle one and a few are long
   // enough to let the block run completely dry.
   function automatic int random_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Colours are biased towards the interesting corners: unlit colours (zero RGB but any
   // alpha) are frequent so that slots drop out of the priority pick again, and fully
   // opaque, fully transparent and saturated colours each get a fair share.
   function automatic logic [COLOR_BITS-1:0] random_argb();
      int roll;
      logic [COLOR_BITS-1:0] argb;
      roll = $urandom_range(0, 99);
      argb = $urandom();
      if (roll < 25)
         argb[23:0] = '0;
      else if (roll < 40)
         argb[31:24] = 8'hFF;
      else if (roll < 50)
         argb[31:24] = 8'h00;
      else if (roll < 55)
         argb = 32'hFFFF_FFFF;
      else if (roll < 60)
         argb = 32'hFF << (8 * $urandom_range(0, 2)) | 32'hFF00_0000;
      return argb;
   endfunction

   function automatic logic [MS_BITS-1:0] random_ms();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return MS_BITS'($urandom());
   endfunction

   function automatic logic [KIND_BITS-1:0] random_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return KIND_BITS'($urandom_range(KIND_FIRST_UNKNOWN, KIND_LAST_UNKNOWN));
      if (roll < 28) return KIND_BACKLIGHT;
      return KIND_BITS'($urandom_range(KIND_ATTENTION, KIND_BATTERY));
   endfunction

   // The receiver holds ready low for random stretches whenever stalls are enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= random_pause() - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offers one request item and holds it until the block takes it. Valid is only
   // dropped when a gap follows, so back-to-back items keep it high without a glitch.
   // A settle request forces an idle gap, so that valid is low before the
   // caller waits for the block to drain.
   task automatic send_light_request(input logic [KIND_BITS-1:0] kind,
                                     input logic [COLOR_BITS-1:0] argb,
                                     input logic timed,
                                     input logic [MS_BITS-1:0] on_ms,
                                     input logic [MS_BITS-1:0] off_ms,
                                     input bit settle);
      int gap;
      gap = (sender_idles && $urandom_range(0, 99) < 40) ? random_pause() : 0;
      if (settle && gap == 0) gap = 1;
      req_bus.valid       <= 1'b1;
      req_bus.light_kind  <= kind;
      req_bus.argb_color  <= argb;
      req_bus.timed_flash <= timed;
      req_bus.on_time_ms  <= on_ms;
      req_bus.off_time_ms <= off_ms;
      do @(posedge clock); while (!req_bus.ready);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every predicted result has been received, then lets the pipeline
   // settle so that a register write cannot overtake an item still in flight.
   task automatic wait_drained();
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [BL_BITS-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wr_data   <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // A short directed run with the reset maxima. It covers unknown slots, the backlight
   // at full, zero and minimal luma, and walks the priority pick through each led slot
   // winning in turn, ending with every slot unlit so that the incoming request is used.
   task automatic run_directed();
      send_light_request(KIND_LAST_UNKNOWN, 32'hFFFF_FFFF, TIMED, '1, '1, 1'b0);
      send_light_request(KIND_FIRST_UNKNOWN, 32'h1234_5678, STEADY, '0, '0, 1'b0);
      send_light_request(KIND_BACKLIGHT, 32'hFFFF_FFFF, STEADY, '0, '0, 1'b0);
      send_light_request(KIND_BACKLIGHT, 32'h00FF_FFFF, TIMED, '1, '1, 1'b0);
      send_light_request(KIND_BACKLIGHT, 32'h80FF_8040, STEADY, '0, '0, 1'b0);
      send_light_request(KIND_BACKLIGHT, 32'hFF00_0009, STEADY, '0, '0, 1'b0);
      send_light_request(KIND_BACKLIGHT, 32'hFF00_0001, STEADY, '0, '0, 1'b0);
      // Battery alone is lit, so it drives the leds at full white.
      send_light_request(KIND_BATTERY, 32'hFFFF_FFFF, STEADY, 16'd100, 16'd200, 1'b0);
      // Notifications outrank battery and blink.
      send_light_request(KIND_NOTIFICATIONS, 32'hFF00_FF00, TIMED, '1, '0, 1'b0);
      // Attention outranks both, even with a barely visible colour.
      send_light_request(KIND_ATTENTION, 32'h0101_0101, TIMED, '0, '1, 1'b0);
      send_light_request(KIND_BATTERY, 32'hFF40_4040, STEADY, '0, '0, 1'b0);
      // Attention goes dark through a zero RGB part; notifications win again.
      send_light_request(KIND_ATTENTION, 32'hFF00_0000, STEADY, '1, '1, 1'b0);
      // Notifications dark as well: the steady battery colour is picked.
      send_light_request(KIND_NOTIFICATIONS, 32'h0000_0000, TIMED, '1, '1, 1'b0);
      // Every slot dark: the incoming request itself is used, timed and then steady.
      send_light_request(KIND_BATTERY, 32'h7F00_0000, TIMED, 16'd1234, 16'd4321, 1'b0);
      send_light_request(KIND_ATTENTION, 32'h0000_0000, STEADY, '0, '0, 1'b0);
      send_light_request(KIND_ATTENTION, 32'h80FF_FFFF, STEADY, '0, '0, 1'b0);
      send_light_request(KIND_ATTENTION, 32'h1200_0000, STEADY, '0, '0, 1'b1);
   endtask

   initial begin : stimulus
      logic [BL_BITS-1:0]  backlight_top;
      logic [BL_BITS-1:0]  white_top, blue_top, green_top;
      logic [KIND_BITS-1:0] kind;
      bit                  pause_here;

      req_bus.valid       <= 1'b0;
      req_bus.light_kind  <= '0;
      req_bus.argb_color  <= '0;
      req_bus.timed_flash <= 1'b0;
      req_bus.on_time_ms  <= '0;
      req_bus.off_time_ms <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.reg_index   <= REG_BACKLIGHT_MAX;
      csr_bus.wr_data     <= '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // The first phase runs on the reset maxima; each later one rewrites every
         // register once the block is idle.
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: begin
                  backlight_top = 12'd1;
                  white_top     = 12'd1;
                  blue_top      = 12'd1;
                  green_top     = 12'd1;
               end
               2: begin
                  // A zero maximum must behave as a maximum of one.
                  backlight_top = 12'd0;
                  white_top     = 12'd0;
                  blue_top      = 12'd0;
                  green_top     = 12'd0;
               end
               3: begin
                  backlight_top = BL_BITS'($urandom_range(1, 4095));
                  white_top     = BL_BITS'($urandom_range(1, 255));
                  blue_top      = BL_BITS'($urandom_range(1, 255));
                  green_top     = BL_BITS'($urandom_range(1, 255));
               end
               4: begin
                  backlight_top = 12'd4095;
                  white_top     = 12'd255;
                  blue_top      = 12'd255;
                  green_top     = 12'd255;
               end
               default: begin
                  // Bits above the led width must be dropped by the register file.
                  backlight_top = BL_BITS'($urandom());
                  white_top     = BL_BITS'($urandom()) | 12'hF00;
                  blue_top      = BL_BITS'($urandom()) | 12'hA00;
                  green_top     = BL_BITS'($urandom()) | 12'h500;
               end
            endcase
            write_register(REG_BACKLIGHT_MAX, backlight_top);
            write_register(REG_WHITE_MAX, white_top);
            write_register(REG_BLUE_MAX, blue_top);
            write_register(REG_GREEN_MAX, green_top);
         end

         // Phase one runs without any idling; phase four stalls only the receiver.
         sender_idles    = (phase != 1 && phase != 4);
         receiver_stalls = (phase != 1);

         if (phase == 0) run_directed();

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Now and then the sender holds off until every result is back.
            pause_here = ($urandom_range(0, 99) < 2);
            kind = random_kind();
            send_light_request(kind, random_argb(), 1'($urandom_range(0, 1)),
                               random_ms(), random_ms(),
                               pause_here || i == ITEMS_PER_PHASE - 1);
            if (pause_here) wait_drained();
         end
      end

      wait_drained();
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
